@@ rtl/core/tdu_pkg.sv @@
package tdu_pkg;

  typedef enum logic [2:0] {
    CMD_TICK  = 3'd0,
    CMD_EDGE  = 3'd1,
    CMD_PUT   = 3'd2,
    CMD_GET   = 3'd3,
    CMD_FLUSH = 3'd4
  } cmd_t;

  localparam int RING_DEPTH = 16;
  localparam int RING_IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int FRAME_BITS = 10;
  localparam int DATA_BITS  = 8;
  localparam int TX_CNT_W   = $clog2(FRAME_BITS + 1);
  localparam int RX_CNT_W   = 4;

  typedef logic [RING_IDX_W-1:0] ring_idx_t;

  function automatic ring_idx_t ring_inc(input ring_idx_t idx);
    ring_idx_t r;
    if (idx == ring_idx_t'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = idx + ring_idx_t'(1);
    end
    return r;
  endfunction

endpackage

@@ rtl/core/tick_driven_uart_with_rx_ring.sv @@
// 8N1 UART stepped by request items: a baud tick, a start edge, a put, a get or a ring
// flush. Every request yields exactly one result, registered, in the cycle after it is
// accepted; a new request is taken every cycle unless the result register is full and
// stalled. The transmitter shifts its 10-bit frame out one bit per tick. The receiver
// arms on a start edge, starts on the next tick, samples 8 data bits on the following
// ticks (LSB first) and writes the byte into a 16-entry ring on one more tick; the stop
// bit is not checked and the ring overwrites when it wraps. The ring is a single
// synchronous RAM with one write port (receive) and one registered read port (get).
// rx_enable may only be written while no request is in flight.
module tick_driven_uart_with_rx_ring (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_enable_we,
  input  logic       rx_enable_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] cmd,
  input  logic       rx_line,
  input  logic [7:0] tx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       tx_line,
  output logic       tx_busy,
  output logic       put_accepted,
  output logic [7:0] rx_data,
  output logic       rx_data_valid,
  output logic       data_available
);
  import tdu_pkg::*;

  logic                  rx_enable;
  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next;
  logic [TX_CNT_W-1:0]   tx_bits_left, tx_bits_left_next;
  logic                  tx_active, tx_active_next;
  logic                  tx_level, tx_level_next;
  logic                  edge_pending, edge_pending_next;
  logic                  edge_enabled, edge_enabled_next;
  logic                  rx_active, rx_active_next;
  logic                  rx_wait_stop, rx_wait_stop_next;
  logic [DATA_BITS-1:0]  rx_shift, rx_shift_next;
  logic [RX_CNT_W-1:0]   rx_bits_left, rx_bits_left_next;
  ring_idx_t             write_index, write_index_next;
  ring_idx_t             read_index, read_index_next;

  logic [7:0] ring [RING_DEPTH];
  logic [7:0] ring_q;
  logic       ring_we, ring_re;

  logic accept, accepted, got;
  logic res_put, res_valid;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    tx_shift_next     = tx_shift;
    tx_bits_left_next = tx_bits_left;
    tx_active_next    = tx_active;
    tx_level_next     = tx_level;
    edge_pending_next = edge_pending;
    edge_enabled_next = edge_enabled;
    rx_active_next    = rx_active;
    rx_wait_stop_next = rx_wait_stop;
    rx_shift_next     = rx_shift;
    rx_bits_left_next = rx_bits_left;
    write_index_next  = write_index;
    read_index_next   = read_index;
    ring_we  = 1'b0;
    ring_re  = 1'b0;
    accepted = 1'b0;
    got      = 1'b0;
    unique case (cmd)
      CMD_TICK: begin
        if (tx_active) begin
          tx_level_next     = tx_shift[0];
          tx_shift_next     = tx_shift >> 1;
          tx_bits_left_next = tx_bits_left - TX_CNT_W'(1);
          if (tx_bits_left == TX_CNT_W'(1)) begin
            tx_active_next = 1'b0;
          end
        end
        if (rx_enable) begin
          if (rx_wait_stop) begin
            edge_pending_next = 1'b0;
            edge_enabled_next = 1'b1;
            rx_wait_stop_next = 1'b0;
            rx_active_next    = 1'b0;
            ring_we           = 1'b1;
            write_index_next  = ring_inc(write_index);
          end else if (!rx_active) begin
            if (edge_pending) begin
              rx_active_next    = 1'b1;
              rx_shift_next     = '0;
              rx_bits_left_next = RX_CNT_W'(DATA_BITS);
            end
          end else begin
            // bits arrive LSB first: shift in at the top
            rx_shift_next     = {rx_line, rx_shift[DATA_BITS-1:1]};
            rx_bits_left_next = rx_bits_left - RX_CNT_W'(1);
            if (rx_bits_left == RX_CNT_W'(1)) begin
              rx_wait_stop_next = 1'b1;
            end
          end
        end
      end
      CMD_EDGE: begin
        if (edge_enabled) begin
          edge_pending_next = 1'b1;
          edge_enabled_next = 1'b0;
        end
      end
      CMD_PUT: begin
        if (!tx_active) begin
          tx_bits_left_next = TX_CNT_W'(FRAME_BITS);
          tx_shift_next     = {1'b1, tx_byte, 1'b0};
          tx_active_next    = 1'b1;
          accepted          = 1'b1;
        end
      end
      CMD_GET: begin
        if (read_index != write_index) begin
          ring_re         = 1'b1;
          got             = 1'b1;
          read_index_next = ring_inc(read_index);
        end
      end
      CMD_FLUSH: begin
        write_index_next = '0;
        read_index_next  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable <= 1'b1;
    end else if (rx_enable_we) begin
      rx_enable <= rx_enable_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift     <= '0;
      tx_bits_left <= '0;
      tx_active    <= 1'b0;
      tx_level     <= 1'b1;
      edge_pending <= 1'b0;
      edge_enabled <= 1'b1;
      rx_active    <= 1'b0;
      rx_wait_stop <= 1'b0;
      rx_shift     <= '0;
      rx_bits_left <= '0;
      write_index  <= '0;
      read_index   <= '0;
    end else if (accept) begin
      tx_shift     <= tx_shift_next;
      tx_bits_left <= tx_bits_left_next;
      tx_active    <= tx_active_next;
      tx_level     <= tx_level_next;
      edge_pending <= edge_pending_next;
      edge_enabled <= edge_enabled_next;
      rx_active    <= rx_active_next;
      rx_wait_stop <= rx_wait_stop_next;
      rx_shift     <= rx_shift_next;
      rx_bits_left <= rx_bits_left_next;
      write_index  <= write_index_next;
      read_index   <= read_index_next;
    end
  end

  // ring RAM; the read register only loads on an accepted get, so it holds under stall
  always_ff @(posedge clk) begin
    if (accept && ring_we) begin
      ring[write_index] <= rx_shift;
    end
    if (accept && ring_re) begin
      ring_q <= ring[read_index];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!in_stall) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      tx_line        <= tx_level_next;
      tx_busy        <= tx_active_next;
      res_put        <= accepted;
      res_valid      <= got;
      data_available <= (read_index_next != write_index_next);
    end
  end

  assign put_accepted  = res_put;
  assign rx_data_valid = res_valid;
  assign rx_data       = res_valid ? ring_q : 8'h00;

  a_tx_count: assert property (@(posedge clk) disable iff (rst)
    tx_active |-> (tx_bits_left != '0))
    else $error("transmitter active with no bits left");

  a_rx_stop: assert property (@(posedge clk) disable iff (rst)
    rx_wait_stop |-> (rx_active && rx_bits_left == '0))
    else $error("stop phase outside a receive");

  a_edge_arm: assert property (@(posedge clk) disable iff (rst)
    !(edge_pending && edge_enabled))
    else $error("edge pending while edge detect enabled");

  a_put_load: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd == CMD_PUT && !tx_active)
      |=> (tx_active && tx_bits_left == TX_CNT_W'(FRAME_BITS) && put_accepted))
    else $error("put did not load frame");

endmodule

@@ tb/sv/tb_tick_driven_uart_with_rx_ring.sv @@
module tb_tick_driven_uart_with_rx_ring;
  import tdu_pkg::*;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_CODE    = 3'd7;
  localparam logic [9:0] STOP_BIT_MARK    = 10'h200;
  localparam int WAIT_MAX     = 5;
  localparam int IDLE_LIMIT   = 500;
  localparam int DRAIN_CYCLES = 4;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       put_accepted;
    logic [7:0] rx_data;
    logic       rx_data_valid;
    logic       data_available;
  } uart_result_t;

  logic       clk;
  logic       rst;
  logic       rx_enable_we;
  logic       rx_enable_wdata;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] cmd;
  logic       rx_line;
  logic [7:0] tx_byte;
  logic       out_valid;
  logic       out_stall;
  logic       tx_line;
  logic       tx_busy;
  logic       put_accepted;
  logic [7:0] rx_data;
  logic       rx_data_valid;
  logic       data_available;

  // UART state as the testbench expects it
  logic       rx_en_m;
  logic [9:0] tx_frame_m;
  logic [3:0] tx_left_m;
  logic       tx_on_m;
  logic       tx_lvl_m;
  logic       edge_armed_m;
  logic       edge_allowed_m;
  logic       rx_on_m;
  logic       rx_stop_m;
  logic [7:0] rx_byte_m;
  logic [3:0] rx_left_m;
  logic [7:0] ring_m [RING_DEPTH];
  ring_idx_t  wr_idx_m;
  ring_idx_t  rd_idx_m;

  uart_result_t pending_results [$];

  int requests_sent;
  int bytes_stored;
  int frames_sent;
  int config_writes;
  int mismatches;
  int idle_cycles;
  bit steady_flow;

  tick_driven_uart_with_rx_ring dut (
    .clk             (clk),
    .rst             (rst),
    .rx_enable_we    (rx_enable_we),
    .rx_enable_wdata (rx_enable_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .cmd             (cmd),
    .rx_line         (rx_line),
    .tx_byte         (tx_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tx_line         (tx_line),
    .tx_busy         (tx_busy),
    .put_accepted    (put_accepted),
    .rx_data         (rx_data),
    .rx_data_valid   (rx_data_valid),
    .data_available  (data_available)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic uart_result_t uart_next_result(input logic [2:0] code, input logic line,
                                                    input logic [7:0] data_in);
    uart_result_t r;
    r = '0;
    case (code)
      CMD_TICK: begin
        if (tx_on_m) begin
          tx_lvl_m   = tx_frame_m[0];
          tx_frame_m = tx_frame_m >> 1;
          tx_left_m  = tx_left_m - 4'd1;
          if (tx_left_m == '0) tx_on_m = 1'b0;
        end
        if (rx_en_m) begin
          if (rx_stop_m) begin
            // byte lands, stop bit is never looked at
            edge_armed_m     = 1'b0;
            edge_allowed_m   = 1'b1;
            rx_stop_m        = 1'b0;
            rx_on_m          = 1'b0;
            ring_m[wr_idx_m] = rx_byte_m;
            wr_idx_m         = ring_idx_t'((int'(wr_idx_m) + 1) % RING_DEPTH);
            bytes_stored++;
          end else if (!rx_on_m) begin
            if (edge_armed_m) begin
              rx_on_m   = 1'b1;
              rx_byte_m = '0;
              rx_left_m = 4'(DATA_BITS);
            end
          end else begin
            if (line && rx_left_m >= 1 && rx_left_m <= DATA_BITS)
              rx_byte_m[DATA_BITS - rx_left_m] = 1'b1;
            rx_left_m = rx_left_m - 4'd1;
            if (rx_left_m == '0) rx_stop_m = 1'b1;
          end
        end
      end
      CMD_EDGE: begin
        if (edge_allowed_m) begin
          edge_armed_m   = 1'b1;
          edge_allowed_m = 1'b0;
        end
      end
      CMD_PUT: begin
        if (!tx_on_m) begin
          tx_left_m      = 4'(FRAME_BITS);
          tx_frame_m     = 10'({data_in, 1'b0}) | STOP_BIT_MARK;
          tx_on_m        = 1'b1;
          r.put_accepted = 1'b1;
          frames_sent++;
        end
      end
      CMD_GET: begin
        if (rd_idx_m != wr_idx_m) begin
          r.rx_data       = ring_m[rd_idx_m];
          r.rx_data_valid = 1'b1;
          rd_idx_m        = ring_idx_t'((int'(rd_idx_m) + 1) % RING_DEPTH);
        end
      end
      CMD_FLUSH: begin
        wr_idx_m = '0;
        rd_idx_m = '0;
      end
      default: ;
    endcase
    r.tx_line        = tx_lvl_m;
    r.tx_busy        = tx_on_m;
    r.data_available = (rd_idx_m != wr_idx_m);
    return r;
  endfunction

  task automatic send_request(input logic [2:0] code, input logic line,
                              input logic [7:0] data_in);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, WAIT_MAX);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid = 1'b1;
    cmd      = code;
    rx_line  = line;
    tx_byte  = data_in;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(uart_next_result(code, line, data_in));
    requests_sent++;
  endtask

  // anything but a tick: cannot shift a frame in or out
  task automatic send_side_request();
    logic [2:0] code;
    case ($urandom_range(0, 9))
      0, 1, 2: code = CMD_PUT;
      3, 4, 5: code = CMD_GET;
      6, 7:    code = CMD_EDGE;
      8:       code = 3'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE));
      default: code = CMD_FLUSH;
    endcase
    send_request(code, 1'($urandom), 8'($urandom));
  endtask

  task automatic receive_frame(input logic [7:0] value, input bit mixed);
    send_request(CMD_EDGE, 1'($urandom), 8'($urandom));
    for (int slot = 0; slot < FRAME_BITS; slot++) begin
      if (mixed && $urandom_range(0, 3) == 0) send_side_request();
      send_request(CMD_TICK, (slot >= 1 && slot <= DATA_BITS) ? value[slot - 1] : 1'($urandom),
                   8'($urandom));
    end
  endtask

  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_rx_enable(input logic value);
    settle_block();
    rx_enable_we    = 1'b1;
    rx_enable_wdata = value;
    @(negedge clk);
    rx_enable_we = 1'b0;
    rx_en_m      = value;
    config_writes++;
  endtask

  task automatic test_idle_requests();
    send_request(CMD_GET, 1'b0, 8'h00);
    send_request(CMD_LAST_CODE, 1'b1, 8'hFF);
    send_request(CMD_FIRST_UNUSED, 1'b0, 8'h5A);
    send_request(CMD_FLUSH, 1'b1, 8'hA5);
  endtask

  task automatic test_loopback_frame();
    send_request(CMD_EDGE, 1'b0, 8'h00);
    send_request(CMD_EDGE, 1'b1, 8'hFF);  // edge detect is off until the byte lands
    send_request(CMD_PUT, 1'b0, 8'h00);
    send_request(CMD_PUT, 1'b1, 8'hFF);   // frame still shifting
    for (int i = 0; i < FRAME_BITS; i++) send_request(CMD_TICK, 1'b1, 8'($urandom));
    send_request(CMD_GET, 1'b0, 8'h00);
    send_request(CMD_GET, 1'b1, 8'hFF);
    send_request(CMD_PUT, 1'b0, 8'hFF);
  endtask

  task automatic test_random_traffic(input int requests);
    int start;
    start = requests_sent;
    while (requests_sent - start < requests) begin
      steady_flow = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 7))
        0, 1, 2: receive_frame(8'($urandom), 1'b1);
        3, 4: begin
          send_request(CMD_PUT, 1'($urandom), 8'($urandom));
          repeat ($urandom_range(1, 12)) send_request(CMD_TICK, 1'($urandom), 8'($urandom));
        end
        5: repeat ($urandom_range(1, 4)) send_request(CMD_GET, 1'($urandom), 8'($urandom));
        6: send_side_request();
        default: send_request(3'($urandom), 1'($urandom), 8'($urandom));
      endcase
    end
    steady_flow = 1'b0;
  endtask

  // more frames than ring entries, no reads in between
  task automatic test_ring_overrun();
    send_request(CMD_FLUSH, 1'($urandom), 8'($urandom));
    repeat (RING_DEPTH + 2) receive_frame(8'($urandom), 1'b0);
    repeat (RING_DEPTH + 2) send_request(CMD_GET, 1'($urandom), 8'($urandom));
  endtask

  task automatic test_receiver_held_off();
    // stop the receiver partway into a frame
    send_request(CMD_EDGE, 1'($urandom), 8'($urandom));
    repeat (4) send_request(CMD_TICK, 1'($urandom), 8'($urandom));
    write_rx_enable(1'b0);
    test_random_traffic(80);
    write_rx_enable(1'b1);
  endtask

  initial begin : result_stall_gen
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = steady_flow ? 0 : $urandom_range(0, WAIT_MAX);
      repeat (hold) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !out_stall));
    end
  end

  always @(posedge clk) begin : check_results
    uart_result_t seen;
    uart_result_t want;
    if (!rst && out_valid === 1'b1 && !out_stall) begin
      seen = {tx_line, tx_busy, put_accepted, rx_data, rx_data_valid, data_available};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with nothing expected: line=%b busy=%b put=%b data=%h dv=%b avail=%b",
                   seen.tx_line, seen.tx_busy, seen.put_accepted, seen.rx_data,
                   seen.rx_data_valid, seen.data_available);
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch: expected line=%b busy=%b put=%b data=%h dv=%b avail=%b",
                     want.tx_line, want.tx_busy, want.put_accepted, want.rx_data,
                     want.rx_data_valid, want.data_available);
            $display("          actual   line=%b busy=%b put=%b data=%h dv=%b avail=%b",
                     seen.tx_line, seen.tx_busy, seen.put_accepted, seen.rx_data,
                     seen.rx_data_valid, seen.data_available);
          end
        end
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("tick_driven_uart_with_rx_ring test failed");
    $finish;
  end

  initial begin : run_tests
    rst             = 1'b1;
    in_valid        = 1'b0;
    cmd             = CMD_TICK;
    rx_line         = 1'b1;
    tx_byte         = '0;
    rx_enable_we    = 1'b0;
    rx_enable_wdata = 1'b0;
    steady_flow     = 1'b0;
    requests_sent   = 0;
    bytes_stored    = 0;
    frames_sent     = 0;
    config_writes   = 0;
    mismatches      = 0;
    rx_en_m         = 1'b1;
    tx_frame_m      = '0;
    tx_left_m       = '0;
    tx_on_m         = 1'b0;
    tx_lvl_m        = 1'b1;
    edge_armed_m    = 1'b0;
    edge_allowed_m  = 1'b1;
    rx_on_m         = 1'b0;
    rx_stop_m       = 1'b0;
    rx_byte_m       = '0;
    rx_left_m       = '0;
    wr_idx_m        = '0;
    rd_idx_m        = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    test_idle_requests();
    test_loopback_frame();
    test_random_traffic(170);
    test_ring_overrun();
    test_receiver_held_off();
    test_random_traffic(170);

    settle_block();
    $display("%0d requests: %0d bytes received into the ring, %0d frames sent, %0d rx_enable writes",
             requests_sent, bytes_stored, frames_sent, config_writes);
    $display("%0d mismatches, %0d results still outstanding", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("tick_driven_uart_with_rx_ring test passed");
    else
      $display("tick_driven_uart_with_rx_ring test failed");
    $finish;
  end

endmodule

@@ tick_driven_uart_with_rx_ring.f @@
rtl/core/tdu_pkg.sv
rtl/core/tick_driven_uart_with_rx_ring.sv
tb/sv/tb_tick_driven_uart_with_rx_ring.sv
